[hw/rtl/hbd_pkg.sv]
// Shared types, codes and defaults of the Huffman table bit decoder.
package hbd_pkg;

	localparam int DefTableEntries = 256;
	localparam int DefMaxCodeLen   = 32;
	localparam int BitsPerByte     = 8;

	// input kinds carried on s_tuser
	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_DATA  = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;  // unused, ignored

	// result status carried on m_tuser
	localparam logic [1:0] ST_SYMBOL   = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_DATA  = 2'd2
	} op_t;

	typedef struct packed {
		logic [7:0] sym;
		logic [1:0] status;
	} res_t;

	typedef struct packed {
		logic idle;
		logic holding;
		logic count_over;
		logic len_over;
	} eng_stat_t;

endpackage

[hw/rtl/hbd_front.sv]
// Front end: classifies input transactions, masks load codes, drops no-ops.
module hbd_front import hbd_pkg::*; #(
	parameter int MaxCodeLen = DefMaxCodeLen,
	localparam int LW = $clog2(MaxCodeLen + 1),
	localparam int KW = MaxCodeLen
) (
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    mode,
	input  logic [7:0]    entry_symbol,
	input  logic [5:0]    code_length,
	input  logic [31:0]   code_bits,
	input  logic [7:0]    data_byte,
	output logic          push_valid,
	input  logic          push_ready,
	output op_t           push_op,
	output logic [7:0]    push_sym,
	output logic [LW-1:0] push_len,
	output logic [KW-1:0] push_code,
	output logic [7:0]    push_byte
);

	logic        len_ok;
	logic        keep;
	logic [63:0] code_ext;

	assign len_ok   = (code_length != 6'd0) && (int'(code_length) <= MaxCodeLen);
	assign code_ext = 64'(code_bits);

	always_comb begin
		unique case (mode)
			MODE_CLEAR: begin
				push_op = OP_CLEAR;
				keep    = 1'b1;
			end
			MODE_LOAD: begin
				push_op = OP_LOAD;
				keep    = len_ok;
			end
			MODE_DATA: begin
				push_op = OP_DATA;
				keep    = 1'b1;
			end
			default: begin
				push_op = OP_CLEAR;
				keep    = 1'b0;
			end
		endcase
	end

	// bits above the code length are ignored
	always_comb begin
		for (int i = 0; i < KW; i++) begin
			push_code[i] = code_ext[i] && (i < int'(code_length));
		end
	end

	assign push_sym   = entry_symbol;
	assign push_len   = LW'(code_length);
	assign push_byte  = data_byte;
	assign push_valid = in_valid && keep;
	// every item, dropped or kept, is taken only when the queue has room
	assign in_ready   = push_ready;

endmodule

[hw/rtl/hbd_queue.sv]
// Two-entry queue between front end and decode engine.
module hbd_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);

	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic         do_wr;
	logic         do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wp_q <= ~wp_q;
			if (do_rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

endmodule

[hw/rtl/hbd_engine.sv]
// Decode engine: code table memory, table scan, pending code and result register.
module hbd_engine import hbd_pkg::*; #(
	parameter int TableEntries = DefTableEntries,
	parameter int MaxCodeLen   = DefMaxCodeLen,
	localparam int LW = $clog2(MaxCodeLen + 1),
	localparam int KW = MaxCodeLen,
	localparam int CW = $clog2(TableEntries + 1),
	localparam int IW = $clog2(TableEntries),
	localparam int BW = $clog2(BitsPerByte + 1),
	localparam int MW = 8 + LW + KW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  op_t           q_op,
	input  logic [7:0]    q_sym,
	input  logic [LW-1:0] q_len,
	input  logic [KW-1:0] q_code,
	input  logic [7:0]    q_byte,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_symbol,
	output logic [1:0]    out_status,
	output logic          out_last,
	output eng_stat_t     stat
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_BIT    = 5'b00010,
		S_SCAN   = 5'b00100,
		S_EMIT   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t        state_q;
	logic [MW-1:0] mem [TableEntries];
	logic [MW-1:0] rd_s1;
	logic          rd_v_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] count_q;
	logic [KW-1:0] pend_q;
	logic [LW-1:0] plen_q;
	logic [7:0]    byte_q;
	logic [BW-1:0] left_q;
	logic          is_data_q;
	logic [7:0]    sym_q;
	logic [LW-1:0] key_len_q;
	logic [KW-1:0] key_code_q;
	res_t          new_q;
	res_t          hold_q;
	logic          hold_v_q;
	logic          out_v_q;
	res_t          out_q;
	logic          out_last_q;

	logic [LW-1:0] key_len;
	logic [KW-1:0] key_code;
	logic [7:0]    rd_sym;
	logic [LW-1:0] rd_len;
	logic [KW-1:0] rd_code;
	logic          hit;
	logic          miss;
	logic          out_free;
	logic          we;
	logic [IW-1:0] wa;
	logic          has_room;

	assign {rd_sym, rd_len, rd_code} = rd_s1;
	assign key_len  = is_data_q ? plen_q : key_len_q;
	assign key_code = is_data_q ? pend_q : key_code_q;
	assign hit      = rd_v_s1 && (rd_len == key_len) && (rd_code == key_code);
	assign miss     = !rd_v_s1 && (idx_q == count_q);
	assign out_free = !out_v_q || out_ready;
	assign has_room = (count_q < CW'(TableEntries));
	assign q_ready  = (state_q == S_IDLE);

	// load writes: replace symbol on a hit, append on a miss with room
	always_comb begin
		we = 1'b0;
		wa = count_q[IW-1:0];
		if (state_q == S_SCAN && !is_data_q) begin
			if (hit) begin
				we = 1'b1;
				wa = rd_idx_s1;
			end else if (miss && has_room) begin
				we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= {sym_q, key_len_q, key_code_q};
		rd_s1 <= mem[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			pend_q    <= '0;
			plen_q    <= '0;
			idx_q     <= '0;
			rd_v_s1   <= 1'b0;
			left_q    <= '0;
			is_data_q <= 1'b0;
			hold_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (out_ready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						sym_q      <= q_sym;
						key_len_q  <= q_len;
						key_code_q <= q_code;
						byte_q     <= q_byte;
						idx_q      <= '0;
						rd_v_s1    <= 1'b0;
						unique case (q_op)
							OP_CLEAR: begin
								count_q <= '0;
								pend_q  <= '0;
								plen_q  <= '0;
							end
							OP_LOAD: begin
								is_data_q <= 1'b0;
								left_q    <= '0;
								state_q   <= S_SCAN;
							end
							OP_DATA: begin
								is_data_q <= 1'b1;
								left_q    <= BW'(BitsPerByte);
								state_q   <= S_BIT;
							end
							default: ;
						endcase
					end
				end
				S_BIT: begin
					pend_q  <= {pend_q[KW-2:0], byte_q[7]};
					plen_q  <= plen_q + 1'b1;
					byte_q  <= {byte_q[6:0], 1'b0};
					left_q  <= left_q - 1'b1;
					idx_q   <= '0;
					rd_v_s1 <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (hit) begin
						rd_v_s1 <= 1'b0;
						if (is_data_q) begin
							new_q   <= '{sym: rd_sym, status: ST_SYMBOL};
							pend_q  <= '0;
							plen_q  <= '0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_FINISH;
						end
					end else if (miss) begin
						if (is_data_q) begin
							if (plen_q == LW'(MaxCodeLen)) begin
								new_q   <= '{sym: 8'd0, status: ST_OVERFLOW};
								pend_q  <= '0;
								plen_q  <= '0;
								state_q <= S_EMIT;
							end else begin
								state_q <= (left_q == '0) ? S_FINISH : S_BIT;
							end
						end else if (has_room) begin
							count_q <= count_q + 1'b1;
							state_q <= S_FINISH;
						end else begin
							new_q   <= '{sym: 8'd0, status: ST_FULL};
							state_q <= S_EMIT;
						end
					end else begin
						rd_v_s1   <= (idx_q != count_q);
						rd_idx_s1 <= idx_q[IW-1:0];
						if (idx_q != count_q) idx_q <= idx_q + 1'b1;
					end
				end
				S_EMIT: begin
					// older held result leaves with last clear
					if (!hold_v_q || out_free) begin
						if (hold_v_q) begin
							out_v_q    <= 1'b1;
							out_q      <= hold_q;
							out_last_q <= 1'b0;
						end
						hold_q   <= new_q;
						hold_v_q <= 1'b1;
						state_q  <= (left_q == '0) ? S_FINISH : S_BIT;
					end
				end
				S_FINISH: begin
					if (!hold_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_v_q    <= 1'b1;
						out_q      <= hold_q;
						out_last_q <= 1'b1;
						hold_v_q   <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_v_q;
	assign out_symbol = out_q.sym;
	assign out_status = out_q.status;
	assign out_last   = out_last_q;

	assign stat.idle       = (state_q == S_IDLE);
	assign stat.holding    = hold_v_q;
	assign stat.count_over = (count_q > CW'(TableEntries));
	assign stat.len_over   = (plen_q > LW'(MaxCodeLen));

endmodule

[hw/rtl/huffman_table_bit_decoder_unit.sv]
// Top level of the Huffman table bit decoder: front end, queue, decode engine.
// A clear is handled in the engine without leaving its idle state. A table load
// scans the stored entries one per cycle through the table memory's single read
// port. A data byte runs eight bit steps, each a full scan of the stored table
// until a match. The front end classifies and buffers up to two items in a queue
// while the engine works, and a result register lets the engine continue while a
// result waits downstream. Mode 3 items and loads of length zero or above the
// maximum are dropped at the front and give no result. No clearing pass is needed
// after reset.
module huffman_table_bit_decoder_unit import hbd_pkg::*; #(
	parameter int TableEntries = DefTableEntries,
	parameter int MaxCodeLen   = DefMaxCodeLen
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// entry_symbol[7:0], code_length[13:8], code_bits[45:14], data_byte[53:46]
	input  logic [55:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// symbol[7:0]
	output logic [7:0]  m_tdata,
	// status[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	localparam int LW = $clog2(MaxCodeLen + 1);
	localparam int KW = MaxCodeLen;
	localparam int QW = 2 + 8 + LW + KW + 8;

	logic          f_valid;
	logic          f_ready;
	op_t           f_op;
	logic [7:0]    f_sym;
	logic [LW-1:0] f_len;
	logic [KW-1:0] f_code;
	logic [7:0]    f_byte;
	logic          e_valid;
	logic          e_ready;
	logic [QW-1:0] e_data;
	logic [1:0]    e_op_bits;
	op_t           e_op;
	logic [7:0]    e_sym;
	logic [LW-1:0] e_len;
	logic [KW-1:0] e_code;
	logic [7:0]    e_byte;
	eng_stat_t     stat;

	hbd_front #(.MaxCodeLen(MaxCodeLen)) u_front (
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.mode         (s_tuser),
		.entry_symbol (s_tdata[7:0]),
		.code_length  (s_tdata[13:8]),
		.code_bits    (s_tdata[45:14]),
		.data_byte    (s_tdata[53:46]),
		.push_valid   (f_valid),
		.push_ready   (f_ready),
		.push_op      (f_op),
		.push_sym     (f_sym),
		.push_len     (f_len),
		.push_code    (f_code),
		.push_byte    (f_byte)
	);

	hbd_queue #(.W(QW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  ({f_op, f_sym, f_len, f_code, f_byte}),
		.rd_valid (e_valid),
		.rd_ready (e_ready),
		.rd_data  (e_data)
	);

	assign {e_op_bits, e_sym, e_len, e_code, e_byte} = e_data;
	assign e_op = op_t'(e_op_bits);

	hbd_engine #(
		.TableEntries (TableEntries),
		.MaxCodeLen   (MaxCodeLen)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (e_valid),
		.q_ready    (e_ready),
		.q_op       (e_op),
		.q_sym      (e_sym),
		.q_len      (e_len),
		.q_code     (e_code),
		.q_byte     (e_byte),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_symbol (m_tdata),
		.out_status (m_tuser),
		.out_last   (m_tlast),
		.stat       (stat)
	);

	// an item never ends with a result still held back
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stat.idle |-> !stat.holding)
		else $error("engine idle with held result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.count_over)
		else $error("entry count above table size");

	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.len_over)
		else $error("pending length above maximum code length");

	// only symbol results carry a symbol
	a_sym_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_SYMBOL) |-> (m_tdata == 8'd0))
		else $error("nonzero symbol on status result");

endmodule
